FILE: hdl/iirmc_pkg.sv
package iirmc_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int FRAC_BITS    = 12;
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int LEN_REG_W    = 4;
  localparam int CH_REG_W     = 2;
  localparam int NUM_FF_LANES = 8;
  localparam int NUM_FB_LANES = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_LO  = 3'd0,
    REG_FF_HI  = 3'd1,
    REG_FB_LO  = 3'd2,
    REG_FB_HI  = 3'd3,
    REG_FF_LEN = 3'd4,
    REG_FB_LEN = 3'd5,
    REG_CH_CNT = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FF,
    ST_FB,
    ST_WB
  } state_t;

endpackage

FILE: hdl/iir_filter_multichannel.sv
// Channel  Direction  Handshake             Payload
// in_      slave      tvalid/tready/tlast   tdata = sample, tuser = present
// out_     master     tvalid/tready/tlast   tdata = filtered_sample, tuser = channel
// cfg_     write      cfg_wr_en             cfg_index selects register, cfg_wdata
//
// For a real sample, one multiply-accumulate is issued per tap (lengths after clamping)
// through a single shared multiplier; the products pass the multiply and accumulate
// registers before the write back. A non-present item goes straight to write back.
// in_tready is low while an item is in work.
// After reset both history memories, MAX_TAPS * MAX_CHANNELS entries each, are swept to
// zero, one entry per cycle, before the first item is taken.
// The result waits in an output register; write back holds while it is not taken.
module iir_filter_multichannel #(
  parameter int MAX_TAPS     = 8,
  parameter int MAX_CHANNELS = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  iirmc_pkg::sample_t       in_tdata,   // [15:0] sample
  input  logic                     in_tuser,   // [0] present
  input  logic                     in_tlast,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output iirmc_pkg::sample_t       out_tdata,  // [15:0] filtered_sample
  output logic                     out_tuser,  // [0] channel
  output logic                     out_tlast,
  input  logic                     cfg_wr_en,
  input  logic [iirmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iirmc_pkg::CFG_W-1:0]     cfg_wdata
);
  import iirmc_pkg::*;

  localparam int DEPTH  = MAX_TAPS * MAX_CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(MAX_TAPS + 1);
  localparam int POS_W  = $clog2(MAX_TAPS);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CHN_W  = $clog2(MAX_CHANNELS + 1);
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(2 * MAX_TAPS) + 1;

  function automatic coef_t lane_sel(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                     input logic [7:0] k, input logic [7:0] nlanes);
    logic [CFG_W-1:0] w;
    coef_t            r;
    w = k[2] ? hi : lo;
    r = w[{k[1:0], 4'b0000} +: COEF_W];
    if (k >= nlanes) r = '0;
    return r;
  endfunction

  // configuration registers
  logic [CFG_W-1:0]     ff_lo_r, ff_hi_r, fb_lo_r, fb_hi_r;
  logic [LEN_REG_W-1:0] ff_len_r, fb_len_r;
  logic [CH_REG_W-1:0]  ch_cnt_r;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [POS_W-1:0]  ring_pos_r, ring_pos_nxt;
  logic [CH_W-1:0]   chan_pos_r, chan_pos_nxt;
  logic [POS_W-1:0]  cur_pos_r;
  logic [CH_W-1:0]   cur_ch_r;
  logic [ADDR_W-1:0] base_r;
  logic [POS_W-1:0]  j_r;
  sample_t           x_r;
  logic              present_r;
  logic              eob_r;

  // pipeline: issue -> multiply -> accumulate
  logic              a_v_r, a_x_r, a_fb_r;
  coef_t             a_coef_r;
  logic              p_v_r, p_neg_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  sample_t sh_mem [DEPTH];
  sample_t oh_mem [DEPTH];
  sample_t sh_rd_r, oh_rd_r;

  logic              out_valid_r, out_ch_r, out_last_r;
  sample_t           out_data_r;

  logic [LEN_W-1:0]  ffl, fbl, len;
  logic [CHN_W-1:0]  chans;
  logic [POS_W-1:0]  pos_n;
  logic [CH_W-1:0]   ch_n;
  logic              accept, issue, clr_we, wb_ready, wb_fire;
  logic              last_ff, last_fb;
  logic [LEN_W:0]    hh;
  logic [ADDR_W-1:0] rd_addr, wb_addr, wr_addr;
  logic              mem_we;
  sample_t           sh_wdata, oh_wdata;
  coef_t             tap_coef;
  sample_t           operand;
  logic signed [ACC_W-1:0] acc_sh;
  logic [ACC_W-1-15:0]     acc_hi;
  sample_t           y_sat;

  // effective lengths and channel count
  always_comb begin
    if (ff_len_r == '0) begin
      ffl = LEN_W'(1);
    end else if (32'(ff_len_r) > MAX_TAPS) begin
      ffl = LEN_W'(MAX_TAPS);
    end else begin
      ffl = LEN_W'(ff_len_r);
    end
    if (fb_len_r == '0) begin
      fbl = LEN_W'(1);
    end else if (32'(fb_len_r) > MAX_TAPS) begin
      fbl = LEN_W'(MAX_TAPS);
    end else begin
      fbl = LEN_W'(fb_len_r);
    end
    len = (ffl > fbl) ? ffl : fbl;
    if (ch_cnt_r == '0) begin
      chans = CHN_W'(1);
    end else if (32'(ch_cnt_r) > MAX_CHANNELS) begin
      chans = CHN_W'(MAX_CHANNELS);
    end else begin
      chans = CHN_W'(ch_cnt_r);
    end
    // drop stale positions left by a configuration change
    pos_n = (LEN_W'(ring_pos_r) >= len) ? '0 : ring_pos_r;
    ch_n  = (CHN_W'(chan_pos_r) >= chans) ? '0 : chan_pos_r;
  end

  assign last_ff = (LEN_W'(j_r) + LEN_W'(1)) == ffl;
  assign last_fb = (LEN_W'(j_r) + LEN_W'(1)) == fbl;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_tvalid) state_nxt = in_tuser ? ST_FF : ST_WB;
      end
      ST_FF: begin
        if (last_ff) state_nxt = (fbl != LEN_W'(1)) ? ST_FB : ST_WB;
      end
      ST_FB: if (last_fb) state_nxt = ST_WB;
      ST_WB: if (wb_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    clr_we    = 1'b0;
    wb_fire   = 1'b0;
    wb_ready  = !a_v_r && !p_v_r && (!out_valid_r || out_tready);
    unique case (state_r)
      ST_CLEAR: clr_we = 1'b1;
      ST_IDLE:  in_tready = 1'b1;
      ST_FF,
      ST_FB:    issue = 1'b1;
      ST_WB:    wb_fire = wb_ready;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // history index of the current tap
  always_comb begin
    hh = {1'b0, LEN_W'(cur_pos_r)} + {1'b0, len} - (LEN_W + 1)'(j_r);
    if (hh >= {1'b0, len}) hh = hh - {1'b0, len};
    rd_addr = base_r + ADDR_W'(hh);
    wb_addr = base_r + ADDR_W'(cur_pos_r);
  end

  always_comb begin
    if (state_r == ST_FB) begin
      tap_coef = lane_sel(fb_lo_r, fb_hi_r, 8'(j_r) - 8'd1, 8'(NUM_FB_LANES));
    end else begin
      tap_coef = lane_sel(ff_lo_r, ff_hi_r, 8'(j_r), 8'(NUM_FF_LANES));
    end
  end

  // floor shift and saturate
  always_comb begin
    acc_sh = acc_r >>> FRAC_BITS;
    acc_hi = acc_sh[ACC_W-1:15];
    if ((&acc_hi) || !(|acc_hi)) begin
      y_sat = acc_sh[SAMPLE_W-1:0];
    end else begin
      y_sat = acc_sh[ACC_W-1] ? sample_t'(16'h8000) : sample_t'(16'h7FFF);
    end
  end

  always_comb begin
    ring_pos_nxt = ring_pos_r;
    chan_pos_nxt = chan_pos_r;
    if (wb_fire && !present_r) begin
      // keep positions cleared as stale, advance nothing
      ring_pos_nxt = cur_pos_r;
      chan_pos_nxt = cur_ch_r;
    end else if (wb_fire) begin
      if ((CHN_W'(cur_ch_r) + CHN_W'(1)) >= chans) begin
        chan_pos_nxt = '0;
        ring_pos_nxt = ((LEN_W'(cur_pos_r) + LEN_W'(1)) >= len) ? '0 : cur_pos_r + POS_W'(1);
      end else begin
        chan_pos_nxt = cur_ch_r + CH_W'(1);
      end
    end
  end

  assign mem_we   = clr_we || (wb_fire && present_r);
  assign wr_addr  = clr_we ? clr_cnt_r : wb_addr;
  assign sh_wdata = clr_we ? '0 : x_r;
  assign oh_wdata = clr_we ? '0 : y_sat;
  assign operand  = a_x_r ? x_r : (a_fb_r ? oh_rd_r : sh_rd_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sh_mem[wr_addr] <= sh_wdata;
      oh_mem[wr_addr] <= oh_wdata;
    end
    sh_rd_r <= sh_mem[rd_addr];
    oh_rd_r <= oh_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_lo_r  <= CFG_W'(4096);
      ff_hi_r  <= '0;
      fb_lo_r  <= '0;
      fb_hi_r  <= '0;
      ff_len_r <= LEN_REG_W'(1);
      fb_len_r <= LEN_REG_W'(1);
      ch_cnt_r <= CH_REG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FF_LO:  ff_lo_r  <= cfg_wdata;
        REG_FF_HI:  ff_hi_r  <= cfg_wdata;
        REG_FB_LO:  fb_lo_r  <= cfg_wdata;
        REG_FB_HI:  fb_hi_r  <= cfg_wdata;
        REG_FF_LEN: ff_len_r <= cfg_wdata[LEN_REG_W-1:0];
        REG_FB_LEN: fb_len_r <= cfg_wdata[LEN_REG_W-1:0];
        REG_CH_CNT: ch_cnt_r <= cfg_wdata[CH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      ring_pos_r  <= '0;
      chan_pos_r  <= '0;
      a_v_r       <= 1'b0;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ring_pos_r <= ring_pos_nxt;
      chan_pos_r <= chan_pos_nxt;
      if (clr_we) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      a_v_r <= issue;
      p_v_r <= a_v_r;
      if (wb_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= in_tdata;
      present_r <= in_tuser;
      eob_r     <= in_tlast;
      cur_pos_r <= pos_n;
      cur_ch_r  <= ch_n;
      base_r    <= ADDR_W'(32'(ch_n) * MAX_TAPS);
      j_r       <= '0;
    end else if (state_r == ST_FF && last_ff) begin
      j_r <= POS_W'(1);
    end else if (issue) begin
      j_r <= j_r + POS_W'(1);
    end

    a_x_r    <= (state_r == ST_FF) && (j_r == '0);
    a_fb_r   <= (state_r == ST_FB);
    a_coef_r <= tap_coef;

    prod_r  <= a_coef_r * operand;
    p_neg_r <= a_fb_r;

    if (accept) begin
      acc_r <= '0;
    end else if (p_v_r) begin
      acc_r <= p_neg_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end

    if (wb_fire) begin
      out_data_r <= present_r ? y_sat : '0;
      out_ch_r   <= cur_ch_r[0];
      out_last_r <= eob_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ch_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/iirmc_checker.sv
module iirmc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               in_tuser,
  input logic               out_tvalid,
  input logic               out_tready,
  input iirmc_pkg::sample_t out_tdata,
  input logic               out_tuser,
  input logic               out_tlast
);

  // reset empties the result side and holds off the input side
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block not quiet after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // a non-present transaction accepted while the output is free returns silence after its write back
  a_silence: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid |=> ##1 out_tvalid && out_tdata == '0)
    else $error("non-present item did not return silence");

endmodule

bind iir_filter_multichannel iirmc_checker u_iirmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: bench/tb.sv
module tb;
  import iirmc_pkg::*;

  localparam int TAPS       = 8;
  localparam int CHANS      = 2;
  localparam int CLEAR_WAIT = 2 * TAPS * CHANS + 8;
  localparam int SETTLE     = 2 * TAPS + 8;
  localparam int STALL_LIMIT = 4000;
  localparam int SEGMENTS   = 10;
  localparam int SEG_ITEMS  = 61;

  typedef struct {
    sample_t value;
    logic    channel;
    logic    last;
  } filt_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  sample_t       in_tdata = '0;
  logic          in_tuser = 1'b0;
  logic          in_tlast = 1'b0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  sample_t       out_tdata;
  logic          out_tuser;
  logic          out_tlast;
  logic          cfg_wr_en = 1'b0;
  cfg_idx_t      cfg_index = REG_FF_LO;
  logic [63:0]   cfg_wdata = '0;

  // filter state mirrored from the block
  logic [63:0]   ff_lo_reg = 64'd4096;
  logic [63:0]   ff_hi_reg = '0;
  logic [63:0]   fb_lo_reg = '0;
  logic [63:0]   fb_hi_reg = '0;
  logic [3:0]    ff_len_reg = 4'd1;
  logic [3:0]    fb_len_reg = 4'd1;
  logic [1:0]    ch_cnt_reg = 2'd1;
  sample_t       sample_hist [TAPS*CHANS] = '{default: '0};
  sample_t       output_hist [TAPS*CHANS] = '{default: '0};
  int            ring_pos = 0;
  int            chan_pos = 0;

  filt_result_t  pending_outputs [$];
  int            mismatch_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            quiet_cycles = 0;

  iir_filter_multichannel #(
    .MAX_TAPS     (TAPS),
    .MAX_CHANNELS (CHANS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] sample
    .in_tuser   (in_tuser),   // [0] present
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [15:0] filtered_sample
    .out_tuser  (out_tuser),  // [0] channel
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int eff_taps(logic [3:0] v);
    if (v == 0) return 1;
    if (v > TAPS) return TAPS;
    return int'(v);
  endfunction

  function automatic longint ff_tap(int j);
    if (j < 4) return longint'(coef_t'(ff_lo_reg[16*j +: 16]));
    if (j < 8) return longint'(coef_t'(ff_hi_reg[16*(j-4) +: 16]));
    return 0;
  endfunction

  function automatic longint fb_tap(int j);
    if (j >= 1 && j <= 4) return longint'(coef_t'(fb_lo_reg[16*(j-1) +: 16]));
    if (j >= 5 && j <= 7) return longint'(coef_t'(fb_hi_reg[16*(j-5) +: 16]));
    return 0;
  endfunction

  task automatic compute_filter_output(sample_t x, logic present, logic eob);
    int ffl, fbl, span, nch, base, h;
    longint acc, y;
    filt_result_t r;
    ffl = eff_taps(ff_len_reg);
    fbl = eff_taps(fb_len_reg);
    span = (ffl > fbl) ? ffl : fbl;
    nch = (ch_cnt_reg == 0) ? 1 : ((ch_cnt_reg > CHANS) ? CHANS : int'(ch_cnt_reg));
    // positions left over from a larger setting restart at zero
    if (ring_pos >= span) ring_pos = 0;
    if (chan_pos >= nch) chan_pos = 0;
    r.channel = chan_pos[0];
    r.last = eob;
    r.value = '0;
    if (present) begin
      base = chan_pos * TAPS;
      acc = ff_tap(0) * longint'(x);
      for (int j = 1; j < ffl; j++) begin
        h = ring_pos + span - j;
        if (h >= span) h -= span;
        acc += ff_tap(j) * longint'(sample_hist[base + h]);
      end
      for (int j = 1; j < fbl; j++) begin
        h = ring_pos + span - j;
        if (h >= span) h -= span;
        acc -= fb_tap(j) * longint'(output_hist[base + h]);
      end
      y = acc >>> FRAC_BITS;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      r.value = sample_t'(y[15:0]);
      sample_hist[base + ring_pos] = x;
      output_hist[base + ring_pos] = r.value;
      if (chan_pos + 1 >= nch) begin
        chan_pos = 0;
        ring_pos = (ring_pos + 1 >= span) ? 0 : ring_pos + 1;
      end else begin
        chan_pos = chan_pos + 1;
      end
    end
    pending_outputs.push_back(r);
  endtask

  always @(posedge clk) begin : check_results
    filt_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected result: filtered_sample %0d channel %0d", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_tdata !== want.value) begin
          $error("filtered_sample: expected %0d, got %0d", want.value, out_tdata);
          mismatch_count++;
        end
        if (out_tuser !== want.channel) begin
          $error("channel: expected %0d, got %0d", want.channel, out_tuser);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $error("end_of_block_out: expected %0d, got %0d", want.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_sample(sample_t s, logic present, logic eob);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    in_tuser <= present;
    in_tlast <= eob;
    do @(posedge clk); while (!in_tready);
    compute_filter_output(s, present, eob);
  endtask

  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    drain_outputs();
    repeat (SETTLE) @(posedge clk);
  endtask

  // leaves the write enable high; callers drop it after the last write
  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_FF_LO:  ff_lo_reg = value;
      REG_FF_HI:  ff_hi_reg = value;
      REG_FB_LO:  fb_lo_reg = value;
      REG_FB_HI:  fb_hi_reg = value;
      REG_FF_LEN: ff_len_reg = value[3:0];
      REG_FB_LEN: fb_len_reg = value[3:0];
      REG_CH_CNT: ch_cnt_reg = value[1:0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand_coeff_word();
    logic [63:0] w;
    case ($urandom_range(7))
      0: w = '0;
      1: w = '1;
      2: w = {4{16'h7FFF}};
      3: w = {4{16'h8000}};
      4: w = {$urandom, $urandom};
      default: begin
        // gentle lanes keep the feedback loop out of saturation
        for (int k = 0; k < 4; k++) w[16*k +: 16] = 16'($urandom_range(2048)) - 16'd1024;
      end
    endcase
    return w;
  endfunction

  function automatic logic [3:0] rand_taps();
    if ($urandom_range(9) == 0) return 4'($urandom_range(15));
    return 4'($urandom_range(TAPS, 1));
  endfunction

  function automatic logic [1:0] rand_chans();
    if ($urandom_range(7) == 0) return 2'($urandom_range(3));
    return 2'($urandom_range(CHANS, 1));
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(3))
      0: return sample_t'($urandom_range(511)) - sample_t'(256);
      1: return $urandom_range(1) ? sample_t'(16'h7FFF) : sample_t'(16'h8000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic random_setup();
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_FF_LO, rand_coeff_word());
    write_reg(REG_FF_HI, rand_coeff_word());
    write_reg(REG_FB_LO, rand_coeff_word());
    write_reg(REG_FB_HI, rand_coeff_word());
    write_reg(REG_FF_LEN, {junk[63:4], rand_taps()});
    write_reg(REG_FB_LEN, {junk[63:4], rand_taps()});
    write_reg(REG_CH_CNT, {junk[63:2], rand_chans()});
    cfg_wr_en <= 1'b0;
  endtask

  // reset setting is a unity-gain single tap
  task automatic test_passthrough();
    send_sample(16'sh7FFF, 1'b1, 1'b0);
    send_sample(16'sh8000, 1'b1, 1'b0);
    send_sample('0, 1'b1, 1'b0);
    send_sample(-16'sd1, 1'b1, 1'b0);
    send_sample(16'sd1, 1'b1, 1'b1);
    send_sample(16'sh1234, 1'b0, 1'b1);
    send_sample(16'sh5A5A, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_saturation();
    write_reg(REG_FF_LO, {32'h0, 16'h7FFF, 16'h7FFF});
    write_reg(REG_FF_LEN, 64'd2);
    write_reg(REG_FB_LEN, 64'd1);
    cfg_wr_en <= 1'b0;
    send_sample(16'sh7FFF, 1'b1, 1'b0);
    send_sample(16'sh7FFF, 1'b1, 1'b0);
    send_sample(16'sh8000, 1'b1, 1'b0);
    send_sample(16'sh8000, 1'b1, 1'b1);
    wait_idle();
    // half gain: negative results round toward minus infinity
    write_reg(REG_FF_LO, 64'h0800);
    write_reg(REG_FF_LEN, 64'd1);
    cfg_wr_en <= 1'b0;
    send_sample(-16'sd1, 1'b1, 1'b0);
    send_sample(16'sd1, 1'b1, 1'b0);
    send_sample(-16'sd3, 1'b1, 1'b0);
    wait_idle();
  endtask

  task automatic test_length_limits();
    // zero lengths and zero channels act as one
    write_reg(REG_FF_LEN, 64'd0);
    write_reg(REG_FB_LEN, 64'd0);
    write_reg(REG_CH_CNT, 64'd0);
    cfg_wr_en <= 1'b0;
    send_sample(16'sh4000, 1'b1, 1'b0);
    send_sample(16'shC000, 1'b1, 1'b1);
    wait_idle();
    // oversized lengths and channel count clamp to the maximum
    write_reg(REG_FF_LO, {4{16'h0400}});
    write_reg(REG_FF_HI, {4{16'h0400}});
    write_reg(REG_FB_LO, {4{16'h0200}});
    write_reg(REG_FB_HI, {16'hFFFF, {3{16'h0200}}});
    write_reg(REG_FF_LEN, 64'd15);
    write_reg(REG_FB_LEN, 64'd15);
    write_reg(REG_CH_CNT, 64'd3);
    cfg_wr_en <= 1'b0;
    send_sample(16'sh7FFF, 1'b1, 1'b0);
    send_sample(16'sh8000, 1'b1, 1'b0);
    send_sample(16'sh2000, 1'b1, 1'b0);
    send_sample(16'sh1000, 1'b0, 1'b0);
    send_sample(16'shE000, 1'b1, 1'b1);
    wait_idle();
    // shrink the ring and drop to one channel: old positions go stale
    write_reg(REG_FF_LEN, 64'd2);
    write_reg(REG_FB_LEN, 64'd1);
    write_reg(REG_CH_CNT, 64'd1);
    cfg_wr_en <= 1'b0;
    send_sample(16'sh0100, 1'b1, 1'b0);
    send_sample(16'sh0200, 1'b1, 1'b0);
    send_sample(16'sh0300, 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      random_setup();
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // hold input until the block has emptied out once per phase
        if (seg == 0 && n == SEG_ITEMS / 2) drain_outputs();
        send_sample(rand_sample(), $urandom_range(9) != 0, $urandom_range(7) == 0);
      end
      wait_idle();
    end
  endtask

  initial begin
    send_idle_pct = 25;
    recv_stall_pct = 87;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (CLEAR_WAIT) @(posedge clk);
    test_passthrough();
    test_saturation();
    test_length_limits();
    test_random_traffic(25, 87);
    test_random_traffic(87, 25);
    test_random_traffic(0, 0);
    drain_outputs();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: iir_filter_multichannel.f
hdl/iirmc_pkg.sv
hdl/iir_filter_multichannel.sv
hdl/iirmc_checker.sv
bench/tb.sv
